### src/klfr_pkg.sv
// Shared types and constants for the keyer link frame receiver.
// Used by the front, queue, back and top-level modules; depends on nothing.
package klfr_pkg;

  localparam int ByteW = 8;

  // Result channel codes
  localparam logic [2:0] CH_RADIO    = 3'd0;
  localparam logic [2:0] CH_FLAGS    = 3'd1;
  localparam logic [2:0] CH_CONTROL  = 3'd2;
  localparam logic [2:0] CH_KEYER    = 3'd3;
  localparam logic [2:0] CH_KEYBOARD = 3'd4;

  // Control message position codes
  localparam logic [1:0] POS_NONE   = 2'd0;
  localparam logic [1:0] POS_FIRST  = 2'd1;
  localparam logic [1:0] POS_MIDDLE = 2'd2;
  localparam logic [1:0] POS_LAST   = 2'd3;

  // Header bit positions
  localparam int HDR_SEQ_CONT  = 6;
  localparam int HDR_RADIO     = 5;
  localparam int HDR_SHARED    = 3;
  localparam int HDR_RADIO_B7  = 2;
  localparam int HDR_SHARED_B7 = 0;
  localparam int BYTE_CONT     = 7;

  localparam logic [2:0] SEQ_CONTROL = 3'd1;
  localparam logic [2:0] SEQ_KEYER   = 3'd2;
  localparam logic [2:0] SEQ_KBD     = 3'd3;
  localparam logic [2:0] SEQ_MAX     = 3'd4;

  // Decoded frame passed from front to back
  typedef struct packed {
    logic             has_radio;
    logic [ByteW-1:0] radio_data;
    logic             has_shared;
    logic [2:0]       shared_channel;
    logic [ByteW-1:0] shared_data;
    logic [1:0]       shared_pos;
  } frame_rec_t;

endpackage

### src/klfr_front.sv
// Front end: accepts serial bytes, assembles four-byte frames and decodes them.
// Pushes one decoded frame record per frame that yields results. Uses klfr_pkg.
module klfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output klfr_pkg::frame_rec_t q_rec
);

  logic [1:0] frame_position;
  logic [7:0] header_byte;
  logic [7:0] radio_raw_byte;
  logic [2:0] sequence_index;
  logic       in_control_message;

  logic       accept;
  logic       cont;
  logic       decode;
  logic [2:0] seq_next;
  logic       has_radio;
  logic       has_shared;
  logic       ctrl_toggle;
  klfr_pkg::frame_rec_t rec;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign cont     = rx_byte[klfr_pkg::BYTE_CONT];
  assign decode   = accept && cont && (frame_position == 2'd3);

  always_comb begin
    if (!header_byte[klfr_pkg::HDR_SEQ_CONT]) begin
      seq_next = 3'd0;
    end else if (sequence_index < klfr_pkg::SEQ_MAX) begin
      seq_next = sequence_index + 3'd1;
    end else begin
      seq_next = sequence_index;
    end

    has_radio  = header_byte[klfr_pkg::HDR_RADIO];
    has_shared = (header_byte[klfr_pkg::HDR_SHARED] || (seq_next == klfr_pkg::SEQ_CONTROL))
                 && (seq_next < klfr_pkg::SEQ_MAX);
    ctrl_toggle = 1'b0;

    rec.has_radio   = has_radio;
    rec.radio_data  = {header_byte[klfr_pkg::HDR_RADIO_B7], radio_raw_byte[6:0]};
    rec.has_shared  = has_shared;
    rec.shared_data = {header_byte[klfr_pkg::HDR_SHARED_B7], rx_byte[6:0]};
    rec.shared_pos  = klfr_pkg::POS_NONE;

    case (seq_next)
      klfr_pkg::SEQ_CONTROL: begin
        rec.shared_channel = klfr_pkg::CH_CONTROL;
        if (header_byte[klfr_pkg::HDR_SHARED]) begin
          rec.shared_pos = klfr_pkg::POS_MIDDLE;
        end else begin
          ctrl_toggle    = 1'b1;
          rec.shared_pos = in_control_message ? klfr_pkg::POS_LAST : klfr_pkg::POS_FIRST;
        end
      end
      klfr_pkg::SEQ_KEYER: rec.shared_channel = klfr_pkg::CH_KEYER;
      klfr_pkg::SEQ_KBD:   rec.shared_channel = klfr_pkg::CH_KEYBOARD;
      default:             rec.shared_channel = klfr_pkg::CH_FLAGS;
    endcase
  end

  assign q_push = decode && (has_radio || has_shared);
  assign q_rec  = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position     <= 2'd0;
      header_byte        <= 8'd0;
      radio_raw_byte     <= 8'd0;
      sequence_index     <= 3'd0;
      in_control_message <= 1'b0;
    end else if (accept) begin
      if (!cont) begin
        // start byte restarts the frame wherever we are
        header_byte    <= rx_byte;
        frame_position <= 2'd1;
      end else begin
        case (frame_position)
          2'd0: frame_position <= 2'd0; // drop stray continuation byte
          2'd1: begin
            radio_raw_byte <= rx_byte;
            frame_position <= 2'd2;
          end
          2'd2: frame_position <= 2'd3;
          default: begin
            frame_position <= 2'd0;
            sequence_index <= seq_next;
            if (ctrl_toggle) begin
              in_control_message <= !in_control_message;
            end
          end
        endcase
      end
    end
  end

endmodule

### src/klfr_queue.sv
// Short queue of decoded frame records between front and back ends.
// Depth set by DEPTH (at least 2). Uses klfr_pkg for the record type.
module klfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  klfr_pkg::frame_rec_t wr_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output klfr_pkg::frame_rec_t rd_rec
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  klfr_pkg::frame_rec_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntFull);
  assign not_empty = (count != '0);
  assign rd_rec    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/klfr_back.sv
// Back end: takes frame records from the queue and emits one result per unstalled cycle.
// Holds the current record in a register that drives the output channel. Uses klfr_pkg.
module klfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  klfr_pkg::frame_rec_t q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           channel,
  output logic [7:0]           data,
  output logic [1:0]           control_position,
  output logic                 last
);

  klfr_pkg::frame_rec_t cur;
  logic cur_valid;
  logic radio_done;

  logic show_radio;
  logic out_accept;
  logic finishing;

  assign show_radio = cur.has_radio && !radio_done;
  assign out_accept = cur_valid && !out_stall;
  // the record is used up when its final result goes out
  assign finishing  = out_accept && !(show_radio && cur.has_shared);
  assign q_pop      = q_not_empty && (!cur_valid || finishing);

  assign out_valid        = cur_valid;
  assign channel          = show_radio ? klfr_pkg::CH_RADIO : cur.shared_channel;
  assign data             = show_radio ? cur.radio_data : cur.shared_data;
  assign control_position = show_radio ? klfr_pkg::POS_NONE : cur.shared_pos;
  assign last             = show_radio ? !cur.has_shared : 1'b1;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      radio_done <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid  <= 1'b1;
        radio_done <= 1'b0;
      end else if (finishing) begin
        cur_valid  <= 1'b0;
        radio_done <= 1'b0;
      end else if (out_accept) begin
        radio_done <= 1'b1;
      end
    end
  end

endmodule

### src/keyer_link_frame_receiver_top.sv
// Keyer link frame receiver, top level.
// Input channel: in_valid / in_stall with rx_byte, one raw serial byte per item.
// Output channel: out_valid / out_stall with channel, data, control_position and
// last, one result per item; a frame gives zero, one or two results.
// Bytes are assembled into four-byte frames by the front end; each frame that
// yields results becomes one record in a QUEUE_DEPTH-deep queue, which the back
// end turns into results.
// Throughput: one input byte per cycle while in_stall is low; the back end emits
// one result per cycle while out_stall is low, so a frame (four bytes, at most two
// results) never limits the input rate. With the back end idle, the first result
// of a frame is registered in the queue at the edge that accepts its fourth byte,
// then in the back-end register that drives the outputs.
// in_stall rises only when the queue is full, which happens only while the
// receiver holds out_stall high; results are then held unchanged until taken.
// Reset (rst, synchronous) empties the queue, drops any partial frame and clears
// the sequence count and control-message state.
// Depends on klfr_pkg, klfr_front, klfr_queue and klfr_back.
module keyer_link_frame_receiver_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] channel,
  output logic [7:0] data,
  output logic [1:0] control_position,
  output logic       last
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_not_empty;
  klfr_pkg::frame_rec_t wr_rec;
  klfr_pkg::frame_rec_t rd_rec;

  klfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (wr_rec)
  );

  klfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_rec    (wr_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_rec    (rd_rec)
  );

  klfr_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_not_empty      (q_not_empty),
    .q_rec            (rd_rec),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .channel          (channel),
    .data             (data),
    .control_position (control_position),
    .last             (last)
  );

endmodule

### src/klfr_checker.sv
// Port-level checks for the keyer link frame receiver, bound to the top level.
// Depends on klfr_pkg for channel and position codes.
module klfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] channel,
  input logic [7:0] data,
  input logic [1:0] control_position,
  input logic       last
);

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(channel) && $stable(data)
      && $stable(control_position) && $stable(last))
    else $error("stalled result changed");

  a_ctrl_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (channel == klfr_pkg::CH_CONTROL) |-> control_position != klfr_pkg::POS_NONE)
    else $error("control result without position");

  a_other_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (channel != klfr_pkg::CH_CONTROL) |-> control_position == klfr_pkg::POS_NONE)
    else $error("position on non-control result");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (channel <= klfr_pkg::CH_KEYBOARD) && (last || channel == klfr_pkg::CH_RADIO))
    else $error("bad channel or missing last on shared result");

endmodule

bind keyer_link_frame_receiver_top klfr_checker u_klfr_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .channel          (channel),
  .data             (data),
  .control_position (control_position),
  .last             (last)
);

### bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for keyer_link_frame_receiver_top: drives raw link bytes, predicts the results
// of each four-byte frame and checks every result in order. Depends on klfr_pkg and the RTL.
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_TAIL     = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_ROWS       = 23;

  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] data;
    logic [1:0] ctrl_pos;
    logic       last;
  } link_result_t;

  typedef struct packed {
    logic [7:0]   rx;
    logic         check;
    link_result_t want;
  } dir_row_t;

  localparam link_result_t NO_RES = '0;

  // Directed bytes; the first result of a completed frame is typed in where obvious.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'hFF, 1'b0, NO_RES},                                   // stray continuation
    '{8'h2D, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{klfr_pkg::CH_RADIO, 8'hFF, klfr_pkg::POS_NONE, 1'b0}},
    '{8'h00, 1'b0, NO_RES},                                   // frame with no results
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h20, 1'b0, NO_RES},
    '{8'h81, 1'b0, NO_RES},
    '{8'h28, 1'b0, NO_RES},                                   // restart mid-frame
    '{8'h85, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b1, '{klfr_pkg::CH_RADIO, 8'h05, klfr_pkg::POS_NONE, 1'b0}},
    '{8'h40, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'hC1, 1'b1, '{klfr_pkg::CH_CONTROL, 8'h41, klfr_pkg::POS_FIRST, 1'b1}},
    '{8'h48, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b1, '{klfr_pkg::CH_KEYER, 8'h00, klfr_pkg::POS_NONE, 1'b1}}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] channel;
  logic [7:0] data;
  logic [1:0] control_position;
  logic       last;

  keyer_link_frame_receiver_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .channel          (channel),
    .data             (data),
    .control_position (control_position),
    .last             (last)
  );

  // Frame decoder state
  logic [1:0] frame_pos;
  logic [7:0] hdr_byte;
  logic [7:0] radio_raw;
  logic [2:0] seq_idx;
  logic       ctrl_open;

  link_result_t pending_results [$];
  int errors      = 0;
  int items_sent  = 0;
  int snd_pct     = 0;
  int rcv_pct     = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    out_stall = 1'b0;
  end

  always #5 clk = ~clk;

  // Advance the frame decoder by one accepted byte and queue the results it gives.
  function automatic void decode_byte(input logic [7:0] b, output link_result_t first_res,
                                      output int n_res);
    link_result_t res [2];
    logic [7:0] hdr;
    n_res = 0;
    first_res = '0;
    if (!b[klfr_pkg::BYTE_CONT]) frame_pos = 2'd0;
    else if (frame_pos == 2'd0) return;
    case (frame_pos)
      2'd0: begin
        hdr_byte = b;
        frame_pos = 2'd1;
      end
      2'd1: begin
        radio_raw = b;
        frame_pos = 2'd2;
      end
      2'd2: frame_pos = 2'd3;
      default: begin
        frame_pos = 2'd0;
        hdr = hdr_byte;
        if (!hdr[klfr_pkg::HDR_SEQ_CONT]) seq_idx = '0;
        else if (seq_idx < klfr_pkg::SEQ_MAX) seq_idx = seq_idx + 3'd1;
        if (hdr[klfr_pkg::HDR_RADIO]) begin
          res[n_res] = '{klfr_pkg::CH_RADIO,
                         {hdr[klfr_pkg::HDR_RADIO_B7], radio_raw[6:0]},
                         klfr_pkg::POS_NONE, 1'b0};
          n_res++;
        end
        if ((hdr[klfr_pkg::HDR_SHARED] || seq_idx == klfr_pkg::SEQ_CONTROL)
            && seq_idx < klfr_pkg::SEQ_MAX) begin
          res[n_res] = '{klfr_pkg::CH_FLAGS,
                         {hdr[klfr_pkg::HDR_SHARED_B7], b[6:0]},
                         klfr_pkg::POS_NONE, 1'b0};
          case (seq_idx)
            klfr_pkg::SEQ_CONTROL: begin
              res[n_res].channel = klfr_pkg::CH_CONTROL;
              if (hdr[klfr_pkg::HDR_SHARED]) begin
                res[n_res].ctrl_pos = klfr_pkg::POS_MIDDLE;
              end else if (!ctrl_open) begin
                res[n_res].ctrl_pos = klfr_pkg::POS_FIRST;
                ctrl_open = 1'b1;
              end else begin
                res[n_res].ctrl_pos = klfr_pkg::POS_LAST;
                ctrl_open = 1'b0;
              end
            end
            klfr_pkg::SEQ_KEYER: res[n_res].channel = klfr_pkg::CH_KEYER;
            klfr_pkg::SEQ_KBD:   res[n_res].channel = klfr_pkg::CH_KEYBOARD;
            default: ;
          endcase
          n_res++;
        end
        if (n_res > 0) begin
          res[n_res-1].last = 1'b1;
          first_res = res[0];
          for (int i = 0; i < n_res; i++) pending_results.push_back(res[i]);
        end
      end
    endcase
  endfunction

  // Offer one byte, hold it until taken, then predict.
  task automatic send_byte(input logic [7:0] b, output link_result_t first_res,
                           output int n_res);
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    decode_byte(b, first_res, n_res);
  endtask

  // Mostly well-formed sequences with random content, some broken frames and stray bytes.
  task automatic send_sequence();
    int n_frames;
    int n_bytes;
    logic [7:0] hdr;
    link_result_t fr;
    int nr;
    n_frames = $urandom_range(1, 6);
    for (int f = 0; f < n_frames; f++) begin
      hdr = 8'($urandom_range(0, 127));
      if ($urandom_range(0, 19) != 0) hdr[klfr_pkg::HDR_SEQ_CONT] = (f != 0);
      n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4;
      send_byte(hdr, fr, nr);
      for (int k = 1; k < n_bytes; k++) send_byte(8'h80 | 8'($urandom_range(0, 127)), fr, nr);
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)), fr, nr);
    end
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  initial begin
    link_result_t first_res;
    int n_res;
    frame_pos = '0;
    hdr_byte = '0;
    radio_raw = '0;
    seq_idx = '0;
    ctrl_open = 1'b0;
    snd_pct = 37;
    rcv_pct = 85;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TABLE[i].rx, first_res, n_res);
      if (DIR_TABLE[i].check && (n_res == 0 || first_res !== DIR_TABLE[i].want)) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("directed byte %0d: expected %h, predicted %h (%0d results)",
                   i, DIR_TABLE[i].want, first_res, n_res);
      end
    end
    while (items_sent < 350) send_sequence();
    drain();

    snd_pct = 85;
    rcv_pct = 37;
    while (items_sent < 700) send_sequence();
    drain();

    snd_pct = 0;
    rcv_pct = 0;
    // Long receiver hold-off while frames flagged for radio and shared results fill the queue.
    hold_reqs <= hold_reqs + 1;
    for (int f = 0; f < 30; f++) begin
      send_byte(8'($urandom_range(0, 127)) | 8'h28, first_res, n_res);
      for (int k = 1; k < 4; k++)
        send_byte(8'h80 | 8'($urandom_range(0, 127)), first_res, n_res);
    end
    while (items_sent < 1040) send_sequence();
    drain();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: check each taken result, then pick the stall for the next cycle.
  always @(posedge clk) begin
    link_result_t got;
    link_result_t want;
    got = '{channel, data, control_position, last};
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result: got %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"result mismatch: expected ch %0d data %h pos %0d last %0d,",
                      " got ch %0d data %h pos %0d last %0d"},
                     want.channel, want.data, want.ctrl_pos, want.last,
                     got.channel, got.data, got.ctrl_pos, got.last);
        end
      end
    end
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_pct);
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
